@@ rtl/variable_format_fixed_point_alu_core_defines.svh @@
// Assertion macros for the fixed-point ALU core.
`ifndef VARIABLE_FORMAT_FIXED_POINT_ALU_CORE_DEFINES_SVH
`define VARIABLE_FORMAT_FIXED_POINT_ALU_CORE_DEFINES_SVH

// Check that cons holds whenever ante holds, in the same cycle.
`define VFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define VFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vfa_pkg.sv @@
package vfa_pkg;

  localparam int TOTAL_BITS = 64;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_SUB    = 3'd1;
  localparam logic [2:0] CMD_MUL    = 3'd2;
  localparam logic [2:0] CMD_MAC    = 3'd3;
  localparam logic [2:0] CMD_CMP    = 3'd4;
  localparam logic [2:0] CMD_SHIFT  = 3'd5;
  localparam logic [2:0] CMD_ASSIGN = 3'd6;
  localparam logic [2:0] CMD_NEG    = 3'd7;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [63:0] MIN_PAT = {1'b1, 63'd0};
  localparam logic [63:0] ALL_ONE = {64{1'b1}};

  // value plus overflow flag
  typedef struct packed {
    logic [63:0] v;
    logic        o;
  } valovf_t;

  // one pipeline slot; each stage fills the fields it owns
  typedef struct packed {
    logic [2:0]        cmd;
    logic [63:0]       a;
    logic [63:0]       b;
    logic [63:0]       acc;
    logic [6:0]        al;
    logic [6:0]        ai;
    logic [6:0]        bl;
    logic [6:0]        bi;
    logic [6:0]        dl;
    logic [6:0]        di;
    logic signed [7:0] n;
    logic [63:0]       ma;
    logic [63:0]       mb;
    logic              pneg;
    logic              pzero;
    logic [63:0]       pp00;
    logic [63:0]       pp01;
    logic [63:0]       pp10;
    logic [63:0]       pp11;
    logic [63:0]       p;
    logic [63:0]       pr;
    logic              povf;
    logic [63:0]       x;
    logic [63:0]       y;
    logic              xo;
    logic              yo;
    logic              xneg;
    logic              yneg;
    logic              forcesat;
    logic [1:0]        ord;
  } pipe_t;

  function automatic logic [63:0] low_mask(input int q);
    logic [63:0] m;
    if (q <= 0) m = '0;
    else if (q >= 64) m = ALL_ONE;
    else m = (64'd1 << q) - 64'd1;
    return m;
  endfunction

  function automatic logic [63:0] sar(input logic [63:0] x, input int k);
    logic [63:0] r;
    if (k <= 0) r = x;
    else if (k >= 64) r = x[63] ? ALL_ONE : '0;
    else r = 64'($signed(x) >>> k);
    return r;
  endfunction

  function automatic valovf_t saturate(input logic neg, input int len);
    valovf_t r;
    r.o = 1'b1;
    r.v = neg ? MIN_PAT : (~MIN_PAT & ~low_mask(TOTAL_BITS - len));
    return r;
  endfunction

  function automatic logic [6:0] clamp_len(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if (v > 7'd64) r = 7'd64;
    else r = v;
    return r;
  endfunction

  function automatic logic [6:0] clamp_int(input logic [6:0] v);
    return (v > 7'd64) ? 7'd64 : v;
  endfunction

  // right by n, left by -n; flag set when a left shift loses the value
  function automatic valovf_t shift_by(input logic [63:0] x, input int n);
    valovf_t r;
    int k;
    r.o = 1'b0;
    k = -n;
    if (n >= 0) begin
      r.v = sar(x, n);
    end else if (k >= 64) begin
      r.v = '0;
      r.o = (x != 64'd0);
    end else begin
      r.v = x << k;
      r.o = (sar(r.v, k) != x);
    end
    return r;
  endfunction

  function automatic valovf_t round_to(input logic [63:0] x, input int len);
    valovf_t r;
    int q;
    q = TOTAL_BITS - len;
    r.o = 1'b0;
    if (len >= TOTAL_BITS) begin
      r.v = x;
    end else begin
      r.v = (x + (64'd1 << (q - 1))) & ~low_mask(q);
      if (!x[63] && r.v[63]) r = saturate(1'b0, len);
    end
    return r;
  endfunction

  function automatic valovf_t prod_fin(input logic [63:0] p, input logic neg,
                                       input logic zero, input int post,
                                       input int dlen);
    valovf_t r;
    logic [63:0] lim;
    logic [63:0] pp;
    int k;
    lim = neg ? MIN_PAT : ~MIN_PAT;
    pp = p;
    k = -post;
    r.o = 1'b0;
    r.v = '0;
    if (!zero) begin
      if (post > 0) begin
        pp = (post >= 64) ? 64'd0 : (pp >> post);
      end
      if (post < 0 && pp != 64'd0 && (k >= 64 || pp > (lim >> k))) begin
        r = saturate(neg, dlen);
      end else begin
        if (post < 0 && pp != 64'd0) pp = pp << k;
        if (pp > lim) r = saturate(neg, dlen);
        else r = round_to(neg ? (64'd0 - pp) : pp, dlen);
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] compare(input logic [63:0] a, input int ai,
                                         input logic [63:0] b, input int bi);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] qs;
    logic        swap;
    logic        rem;
    logic [1:0]  res;
    int d;
    swap = (ai < bi);
    p = swap ? b : a;
    q = swap ? a : b;
    d = swap ? (bi - ai) : (ai - bi);
    qs = sar(q, d);
    if (d >= 64) rem = q[63] ? 1'b1 : (q != 64'd0);
    else rem = ((q & low_mask(d)) != 64'd0);
    if ($signed(p) < $signed(qs)) res = swap ? ORD_GT : ORD_LT;
    else if ($signed(p) > $signed(qs)) res = swap ? ORD_LT : ORD_GT;
    else if (rem) res = swap ? ORD_GT : ORD_LT;
    else res = ORD_EQ;
    if (a[63] != b[63]) res = a[63] ? ORD_LT : ORD_GT;
    return res;
  endfunction

endpackage

@@ rtl/variable_format_fixed_point_alu_core.sv @@
// Seven register stages (s1_r to s6_r and the out_* registers) lie between
//   an input item and its result on out_*; the accepting edge loads the first.
// Throughput: one item per cycle; the whole pipe advances unless out_stall
//   holds a waiting result, and then in_stall rises in the same cycle.
// The 64x64 product is cut into four 32x32 partial products in one stage.
// Reset (rst_n low, synchronous): all valid bits clear, pipe empties.
`include "variable_format_fixed_point_alu_core_defines.svh"

module variable_format_fixed_point_alu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [63:0] in_a_bits,
  input  logic [6:0]  in_a_len,
  input  logic [6:0]  in_a_int,
  input  logic [63:0] in_b_bits,
  input  logic [6:0]  in_b_len,
  input  logic [6:0]  in_b_int,
  input  logic [63:0] in_accum_bits,
  input  logic [6:0]  in_dst_len,
  input  logic [6:0]  in_dst_int,
  input  logic [7:0]  in_shift_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_bits,
  output logic        out_overflow,
  output logic [1:0]  out_order
);
  import vfa_pkg::*;

  logic [6:1] v_r, v_nxt;
  pipe_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;
  pipe_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_res_r, out_res_nxt;
  logic        out_ovf_r, out_ovf_nxt;
  logic [1:0]  out_ord_r, out_ord_nxt;
  logic [2:0]  out_cmd_r, out_cmd_nxt;

  // Global advance: move every stage when the output slot is free or taken.
  logic en;
  assign en = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Stage 1: clamp formats, drop bits below each operand's length.
  always_comb begin
    s1_nxt = '0;
    s1_nxt.cmd = in_command;
    s1_nxt.al  = clamp_len(in_a_len);
    s1_nxt.bl  = clamp_len(in_b_len);
    s1_nxt.dl  = clamp_len(in_dst_len);
    s1_nxt.ai  = clamp_int(in_a_int);
    s1_nxt.bi  = clamp_int(in_b_int);
    s1_nxt.di  = clamp_int(in_dst_int);
    s1_nxt.n   = $signed(in_shift_amount);
    s1_nxt.a   = in_a_bits & (ALL_ONE << (7'd64 - s1_nxt.al));
    s1_nxt.b   = in_b_bits & (ALL_ONE << (7'd64 - s1_nxt.bl));
    s1_nxt.acc = in_accum_bits & (ALL_ONE << (7'd64 - s1_nxt.dl));
  end

  // Stage 2: operand magnitudes and product sign.
  always_comb begin
    s2_nxt = s1_r;
    s2_nxt.pneg  = s1_r.a[63] ^ s1_r.b[63];
    s2_nxt.pzero = (s1_r.a == 64'd0) || (s1_r.b == 64'd0);
    s2_nxt.ma    = s1_r.a[63] ? (64'd0 - s1_r.a) : s1_r.a;
    s2_nxt.mb    = s1_r.b[63] ? (64'd0 - s1_r.b) : s1_r.b;
  end

  // Stage 3: four 32x32 partial products.
  always_comb begin
    s3_nxt = s2_r;
    s3_nxt.pp00 = 64'(s2_r.ma[31:0])  * 64'(s2_r.mb[31:0]);
    s3_nxt.pp01 = 64'(s2_r.ma[31:0])  * 64'(s2_r.mb[63:32]);
    s3_nxt.pp10 = 64'(s2_r.ma[63:32]) * 64'(s2_r.mb[31:0]);
    s3_nxt.pp11 = 64'(s2_r.ma[63:32]) * 64'(s2_r.mb[63:32]);
  end

  // Stage 4: sum partials; keep the product bits at 64-bit precision.
  logic [127:0] prod_full;
  always_comb begin
    prod_full = {64'd0, s3_r.pp00} + {32'd0, s3_r.pp01, 32'd0}
              + {32'd0, s3_r.pp10, 32'd0} + {s3_r.pp11, 64'd0};
    s4_nxt = s3_r;
    s4_nxt.p = prod_full[126:63];
  end

  // Stage 5: scale, limit and round the product. A mac keeps it at the
  // full product format; a mul goes straight to the destination format.
  valovf_t pf;
  int      pint;
  always_comb begin
    pint = int'(s4_r.ai) + int'(s4_r.bi) - 1;
    if (s4_r.cmd == CMD_MAC) begin
      pf = prod_fin(s4_r.p, s4_r.pneg, s4_r.pzero, 0,
                    int'(s4_r.al) + int'(s4_r.bl) - 1);
    end else begin
      pf = prod_fin(s4_r.p, s4_r.pneg, s4_r.pzero, int'(s4_r.di) - pint,
                    int'(s4_r.dl));
    end
    s5_nxt = s4_r;
    s5_nxt.pr   = pf.v;
    s5_nxt.povf = pf.o;
  end

  // Stage 6: align operands to the destination, compare.
  valovf_t xs, ys;
  logic [63:0] x0, y0;
  int sx, sy, sneg;
  always_comb begin
    s6_nxt = s5_r;
    x0 = s5_r.a;
    y0 = s5_r.b;
    sx = int'(s5_r.di) - int'(s5_r.ai);
    sy = int'(s5_r.di) - int'(s5_r.bi);
    sneg = int'(s5_r.di) - int'(s5_r.ai);
    s6_nxt.forcesat = 1'b0;
    unique case (s5_r.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_CMP, CMD_ASSIGN: begin
      end
      CMD_MAC: begin
        x0 = s5_r.acc;
        sx = 0;
        y0 = s5_r.pr;
        sy = int'(s5_r.di) - (int'(s5_r.ai) + int'(s5_r.bi) - 1 + int'(s5_r.n));
      end
      CMD_SHIFT: begin
        sx = int'(s5_r.n);
      end
      CMD_NEG: begin
        if (s5_r.a == MIN_PAT) begin
          // exact positive value of the most negative pattern
          sx = 0;
          s6_nxt.forcesat = (sneg < 1);
          x0 = (sneg >= 64 || sneg < 1) ? 64'd0 : (64'd1 << (63 - sneg));
        end else begin
          x0 = 64'd0 - s5_r.a;
        end
      end
      default: begin
      end
    endcase
    xs = shift_by(x0, sx);
    ys = shift_by(y0, sy);
    s6_nxt.x    = xs.v;
    s6_nxt.xo   = xs.o;
    s6_nxt.xneg = x0[63];
    s6_nxt.y    = ys.v;
    s6_nxt.yo   = ys.o;
    s6_nxt.yneg = y0[63] ^ (s5_r.cmd == CMD_SUB);
    s6_nxt.ord  = compare(s5_r.a, int'(s5_r.ai), s5_r.b, int'(s5_r.bi));
  end

  // Stage 7: combine, detect overflow, round and saturate.
  valovf_t fin;
  logic [63:0] sum, vbits;
  always_comb begin
    sum   = (s6_r.cmd == CMD_SUB) ? (s6_r.x - s6_r.y) : (s6_r.x + s6_r.y);
    vbits = (s6_r.cmd == CMD_SUB) ? ((s6_r.x ^ s6_r.y) & (s6_r.x ^ sum))
                                  : ((s6_r.x ^ sum) & (s6_r.y ^ sum));
    out_ord_nxt = ORD_LT;
    unique case (s6_r.cmd)
      CMD_ADD, CMD_SUB, CMD_MAC: begin
        if (s6_r.cmd == CMD_MAC && s6_r.povf) fin = saturate(s6_r.pneg, int'(s6_r.dl));
        else if (s6_r.xo) fin = saturate(s6_r.xneg, int'(s6_r.dl));
        else if (s6_r.yo) fin = saturate(s6_r.yneg, int'(s6_r.dl));
        else if (vbits[63]) fin = saturate(s6_r.x[63], int'(s6_r.dl));
        else fin = round_to(sum, int'(s6_r.dl));
      end
      CMD_MUL: begin
        fin.v = s6_r.pr;
        fin.o = s6_r.povf;
      end
      CMD_CMP: begin
        fin = '0;
        out_ord_nxt = s6_r.ord;
      end
      CMD_SHIFT, CMD_ASSIGN, CMD_NEG: begin
        if (s6_r.forcesat) fin = saturate(1'b0, int'(s6_r.dl));
        else if (s6_r.xo) fin = saturate(s6_r.xneg, int'(s6_r.dl));
        else fin = round_to(s6_r.x, int'(s6_r.dl));
      end
      default: fin = '0;
    endcase
    out_res_nxt = fin.v;
    out_ovf_nxt = fin.o;
    out_cmd_nxt = s6_r.cmd;
  end

  // Valid bits travel with their slot; hold everything while stalled.
  always_comb begin
    v_nxt = {v_r[5:1], in_valid};
    out_valid_nxt = v_r[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      out_res_r <= out_res_nxt;
      out_ovf_r <= out_ovf_nxt;
      out_ord_r <= out_ord_nxt;
      out_cmd_r <= out_cmd_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_res_r;
  assign out_overflow    = out_ovf_r;
  assign out_order       = out_ord_r;

  `VFA_ASSERT_NOW(a_order_only_cmp, out_valid_r && out_ord_r != ORD_LT, out_cmd_r == CMD_CMP, "order set on a non-compare item")
  `VFA_ASSERT_NOW(a_cmp_zero, out_valid_r && out_cmd_r == CMD_CMP, out_res_r == 64'd0 && !out_ovf_r, "compare result not zero")
  `VFA_ASSERT_NEXT(a_pipe_drain, v_r[6] && en, out_valid_r, "last stage item lost")

endmodule
